[hw/rtl/frae_pkg.sv]
// Shared types and constants for the four-register ALU executor.
package frae_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned CNT_W  = 6;

  // Last value of the step counter for the multi-cycle operations.
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

  // Partial product phases of the shared 32x32 multiplier.
  localparam logic [1:0] MUL_LO_LO = 2'd0;
  localparam logic [1:0] MUL_LO_HI = 2'd1;
  localparam logic [1:0] MUL_HI_LO = 2'd2;
  localparam logic [1:0] MUL_DRAIN = 2'd3;

  typedef enum logic [2:0] {
    OP_INPUT = 3'd0,
    OP_ADD   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MOD   = 3'd4,
    OP_EQL   = 3'd5
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       mul_step;
    logic [1:0] mul_phase;
    logic       finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    b_zero;
  } dp_stat_t;

endpackage

[hw/rtl/four_register_alu_executor.sv]
// Top level of the four-register integer ALU executor.
//
// Each input beat carries one decoded instruction that acts on four 64-bit
// signed registers (w, x, y, z). Each instruction gives exactly one result
// beat with the destination index, its new value, a divide-by-zero flag and
// the value of z after the instruction.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. One instruction is worked on at a time: in_stall is low only
// while the block is idle.
// An accepted beat is loaded into the operand registers and then decoded. Input,
// add, compare and zero-divisor cases go straight to the commit; multiply forms
// three 32x32 partial products through one shared multiplier, and divide and
// remainder run the restoring divider, which makes one quotient bit per cycle.
// The next instruction is accepted only after this one has committed its
// result to the output register.
// The result sits in an output register, so the next instruction is accepted
// and executed while a stalled result waits; it then holds before its
// register write until the output register is freed.
// A synchronous reset (rst_n low) clears all four registers to zero and
// drops out_valid.
module four_register_alu_executor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [1:0]         in_dest_reg,
  input  logic               in_src_is_immediate,
  input  logic [1:0]         in_src_reg,
  input  logic signed [31:0] in_immediate,
  input  logic signed [31:0] in_input_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_written_reg,
  output logic signed [63:0] out_written_value,
  output logic               out_divide_by_zero,
  output logic signed [63:0] out_z_value
);
  import frae_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Instruction sequencer.
  frae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Registers and arithmetic.
  frae_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_opcode),
    .in_dest_reg         (in_dest_reg),
    .in_src_is_immediate (in_src_is_immediate),
    .in_src_reg          (in_src_reg),
    .in_immediate        (in_immediate),
    .in_input_value      (in_input_value),
    .out_written_reg     (out_written_reg),
    .out_written_value   (out_written_value),
    .out_divide_by_zero  (out_divide_by_zero),
    .out_z_value         (out_z_value)
  );

endmodule

[hw/rtl/frae_dpath.sv]
// Datapath: register file, operand registers, multiplier, divider and result mux.
module frae_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  frae_pkg::dp_cmd_t  cmd,
  output frae_pkg::dp_stat_t stat,
  input  logic [2:0]         in_opcode,
  input  logic [1:0]         in_dest_reg,
  input  logic               in_src_is_immediate,
  input  logic [1:0]         in_src_reg,
  input  logic signed [31:0] in_immediate,
  input  logic signed [31:0] in_input_value,
  output logic [1:0]         out_written_reg,
  output logic signed [63:0] out_written_value,
  output logic               out_divide_by_zero,
  output logic signed [63:0] out_z_value
);
  import frae_pkg::*;

  logic [DATA_W-1:0] rf_r [4];

  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;
  logic [DATA_W-1:0] inval_r;
  opcode_t           op_r;
  logic [1:0]        dest_r;

  logic [DATA_W-1:0] pp_r;
  logic [DATA_W-1:0] acc_r;

  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic              neg_q_r;
  logic              neg_rem_r;

  logic [1:0]        wr_reg_r;
  logic [DATA_W-1:0] wr_val_r;
  logic              dz_r;
  logic [DATA_W-1:0] z_val_r;

  logic [HALF_W-1:0] mul_x;
  logic [HALF_W-1:0] mul_y;
  logic [DATA_W-1:0] prod;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              b_zero;
  logic              dz;
  logic [DATA_W-1:0] res;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    magnitude = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  assign b_zero = (b_r == '0);
  assign stat   = '{op: op_r, b_zero: b_zero};

  // Shared multiplier: one 32x32 partial product per phase.
  always_comb begin
    mul_x = (cmd.mul_phase == MUL_HI_LO) ? a_r[DATA_W-1:HALF_W] : a_r[HALF_W-1:0];
    mul_y = (cmd.mul_phase == MUL_LO_HI) ? b_r[DATA_W-1:HALF_W] : b_r[HALF_W-1:0];
    prod  = DATA_W'(mul_x) * DATA_W'(mul_y);
  end

  // Restoring divider step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  // Result of the instruction held in the operand registers.
  always_comb begin
    res = a_r;
    dz  = 1'b0;
    case (op_r)
      OP_INPUT: res = inval_r;
      OP_ADD:   res = a_r + b_r;
      OP_MUL:   res = acc_r;
      OP_DIV: begin
        if (b_zero) begin
          dz = 1'b1;
        end else begin
          res = neg_q_r ? (~quo_r + DATA_W'(1)) : quo_r;
        end
      end
      OP_MOD: begin
        if (b_zero) begin
          dz = 1'b1;
        end else begin
          res = neg_rem_r ? (~rem_r + DATA_W'(1)) : rem_r;
        end
      end
      OP_EQL:   res = {{(DATA_W-1){1'b0}}, (a_r == b_r)};
      default:  res = a_r;
    endcase
  end

  // Register file: written at the end of an instruction, read at load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        rf_r[i] <= '0;
      end
    end else if (cmd.finish) begin
      rf_r[dest_r] <= res;
    end
  end

  // Operand capture; the source is read before this instruction writes.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r     <= rf_r[in_dest_reg];
      b_r     <= in_src_is_immediate ? DATA_W'(in_immediate) : rf_r[in_src_reg];
      inval_r <= DATA_W'(in_input_value);
      op_r    <= opcode_t'(in_opcode);
      dest_r  <= in_dest_reg;
    end
  end

  // Multiply: register each partial product, then add it in the next cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      if (cmd.mul_phase != MUL_DRAIN) begin
        pp_r <= prod;
      end
      case (cmd.mul_phase)
        MUL_LO_HI: acc_r <= pp_r;
        MUL_HI_LO,
        MUL_DRAIN: acc_r <= acc_r + {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};
        default:   acc_r <= acc_r;
      endcase
    end
  end

  // Divide: unsigned magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r     <= '0;
      quo_r     <= magnitude(a_r);
      dvs_r     <= magnitude(b_r);
      neg_q_r   <= a_r[DATA_W-1] ^ b_r[DATA_W-1];
      neg_rem_r <= a_r[DATA_W-1];
    end else if (cmd.div_step) begin
      if (!trial[DATA_W]) begin
        rem_r <= trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Output register for the result beat.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      wr_reg_r <= dest_r;
      wr_val_r <= res;
      dz_r     <= dz;
      z_val_r  <= (dest_r == 2'd3) ? res : rf_r[3];
    end
  end

  assign out_written_reg    = wr_reg_r;
  assign out_written_value  = wr_val_r;
  assign out_divide_by_zero = dz_r;
  assign out_z_value        = z_val_r;

endmodule

[hw/rtl/frae_ctrl.sv]
// Controller: sequences each instruction and runs the result handshake.
module frae_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output frae_pkg::dp_cmd_t  cmd,
  input  frae_pkg::dp_stat_t stat
);
  import frae_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state, counter and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_phase = cnt_r[1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_nxt = '0;
        if (stat.op == OP_MUL) begin
          state_nxt = S_MUL;
        end else if ((stat.op inside {OP_DIV, OP_MOD}) && !stat.b_zero) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // Commit only when the output register is free or being emptied.
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
